### sv/sacl_pkg.sv
// Shared constants for the set-associative cache lookup core with LRU replacement.
// Holds the default geometry, register indexes and stream widths.
// No dependencies.
package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int WAYS_DEF         = 4;

  localparam int ADDR_W  = 32;
  localparam int TOTAL_W = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_USED  = 2'd2;

  localparam int SET_BITS_W   = 3;
  localparam int BLOCK_BITS_W = 5;
  localparam int WAYS_USED_W  = 3;

  localparam int RESULT_BITS  = 2 + 3 * TOTAL_W;
  localparam int OUT_DATA_W   = ((RESULT_BITS + 7) / 8) * 8;

endpackage

### sv/set_assoc_cache_lru_lookup_core.sv
// Set-associative cache lookup core with least-recently-used replacement.
// Keeps tags and recency ranks in a synchronous row memory, valid bits in flops.
// Depends on sacl_pkg.
//
// Usage: each request on the s_axis channel carries one 32-bit byte address.
// The address is split into offset, set index and tag by the set_bits and
// block_bits registers; ways_used limits how many lines of each set are used.
// Each request produces exactly one result on the m_axis channel with the hit
// and eviction flags and the running hit, miss and eviction totals.
// Configuration is written through the cfg channel, which is always ready.
// An accepted request reads its set row from the tag and rank memory into
// registers; in the compare state that follows, the tags are compared, the LRU
// victim is chosen and the row is written back once the output register is free.
// A new request is taken only after that write.
// The output register holds a result while the receiver stalls; the next
// request is still accepted and then waits in its compare cycle until the
// output register is free.
// Reset clears all valid bits and the totals and returns the registers to their
// defaults at once; no clearing pass is needed.
module set_assoc_cache_lru_lookup_core #(
  parameter int MAX_SET_BITS = sacl_pkg::MAX_SET_BITS_DEF,
  parameter int WAYS         = sacl_pkg::WAYS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sacl_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: address[31:0].
  input  logic [sacl_pkg::ADDR_W-1:0]        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: hit, evicted, hit_total[31:0], miss_total[31:0],
  // evict_total[31:0], zero fill.
  output logic [sacl_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SIDX_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int POS_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W   = $clog2(WAYS + 1);
  localparam int AW       = sacl_pkg::ADDR_W;
  localparam int TW       = sacl_pkg::TOTAL_W;
  localparam int SET_BITS_W_L = sacl_pkg::SET_BITS_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  typedef logic [WAYS-1:0][AW-1:0]     tag_row_t;
  typedef logic [WAYS-1:0][RANK_W-1:0] rank_row_t;

  logic [sacl_pkg::SET_BITS_W-1:0]   set_bits;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] block_bits;
  logic [sacl_pkg::WAYS_USED_W-1:0]  ways_used;

  logic                 state;
  logic [SIDX_W-1:0]    set_q;
  logic [AW-1:0]        tag_q;
  logic [WCNT_W-1:0]    ways_q;

  tag_row_t             tag_mem  [NUM_SETS];
  rank_row_t            rank_mem [NUM_SETS];
  tag_row_t             rd_tags;
  rank_row_t            rd_ranks;
  logic [NUM_SETS-1:0][WAYS-1:0] valid;

  logic [TW-1:0]        hit_cnt;
  logic [TW-1:0]        miss_cnt;
  logic [TW-1:0]        evict_cnt;
  logic                 hit_out;
  logic                 evict_out;

  logic                 accept;
  logic                 commit;
  logic [SET_BITS_W_L-1:0] sb;
  logic [AW-1:0]        addr_shift;
  logic [AW-1:0]        set_mask;
  logic [5:0]           tshift;
  logic [SIDX_W-1:0]    set_in;
  logic [AW-1:0]        tag_in;
  logic [WCNT_W-1:0]    ways_in;

  logic                 hit;
  logic                 have_free;
  logic [POS_W-1:0]     pos;
  logic [WAYS-1:0]      line_vld;
  rank_row_t            new_ranks;
  tag_row_t             new_tags;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == S_LOOK) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    if (32'(set_bits) > MAX_SET_BITS) begin
      sb = SET_BITS_W_L'(MAX_SET_BITS);
    end else begin
      sb = set_bits;
    end
    addr_shift = s_axis_tdata >> block_bits;
    set_mask   = (AW'(1) << sb) - AW'(1);
    set_in     = SIDX_W'(addr_shift & set_mask);
    tshift     = 6'(sb) + 6'(block_bits);
    if (tshift >= 6'd32) begin
      tag_in = '0;
    end else begin
      tag_in = s_axis_tdata >> tshift[4:0];
    end
    if (ways_used == '0) begin
      ways_in = WCNT_W'(1);
    end else if (32'(ways_used) > WAYS) begin
      ways_in = WCNT_W'(WAYS);
    end else begin
      ways_in = WCNT_W'(ways_used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= '0;
      block_bits <= '0;
      ways_used  <= sacl_pkg::WAYS_USED_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sacl_pkg::REG_SET_BITS:   set_bits   <= cfg_data[sacl_pkg::SET_BITS_W-1:0];
        sacl_pkg::REG_BLOCK_BITS: block_bits <= cfg_data[sacl_pkg::BLOCK_BITS_W-1:0];
        sacl_pkg::REG_WAYS_USED:  ways_used  <= cfg_data[sacl_pkg::WAYS_USED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_tags  <= tag_mem[set_in];
      rd_ranks <= rank_mem[set_in];
      set_q    <= set_in;
      tag_q    <= tag_in;
      ways_q   <= ways_in;
    end
    if (commit) begin
      tag_mem[set_q]  <= new_tags;
      rank_mem[set_q] <= new_ranks;
    end
  end

  always_comb begin
    logic [WAYS-1:0]   in_use;
    logic [WAYS-1:0]   match;
    logic [POS_W-1:0]  hit_pos;
    logic [POS_W-1:0]  free_pos;
    logic [POS_W-1:0]  victim;
    logic [RANK_W-1:0] best;
    logic [RANK_W-1:0] old_rank;
    logic              age_all;
    in_use    = '0;
    match     = '0;
    hit       = 1'b0;
    have_free = 1'b0;
    hit_pos   = '0;
    free_pos  = '0;
    for (int w = 0; w < WAYS; w++) begin
      in_use[w]   = (WCNT_W'(w) < ways_q);
      line_vld[w] = valid[set_q][w] && in_use[w];
      match[w]    = line_vld[w] && (rd_tags[w] == tag_q);
      if (in_use[w] && !valid[set_q][w]) begin
        have_free = 1'b1;
        free_pos  = POS_W'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_pos = POS_W'(w);
      end
    end
    hit    = |match;
    victim = '0;
    best   = rd_ranks[0];
    for (int w = 1; w < WAYS; w++) begin
      if (in_use[w] && (rd_ranks[w] > best)) begin
        best   = rd_ranks[w];
        victim = POS_W'(w);
      end
    end
    priority if (hit) begin
      pos      = hit_pos;
      old_rank = rd_ranks[hit_pos];
      age_all  = 1'b0;
    end else if (have_free) begin
      pos      = free_pos;
      old_rank = best;
      age_all  = 1'b1;
    end else begin
      pos      = victim;
      old_rank = best;
      age_all  = 1'b0;
    end
    new_tags  = rd_tags;
    new_ranks = rd_ranks;
    if (!hit) begin
      new_tags[pos] = tag_q;
    end
    for (int w = 0; w < WAYS; w++) begin
      if ((POS_W'(w) != pos) && line_vld[w] && (age_all || (rd_ranks[w] < old_rank))
          && (rd_ranks[w] < RANK_MAX)) begin
        new_ranks[w] = rd_ranks[w] + RANK_W'(1);
      end
    end
    new_ranks[pos] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid         <= '0;
      hit_cnt       <= '0;
      miss_cnt      <= '0;
      evict_cnt     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= S_LOOK;
      end
      if (commit) begin
        state         <= S_IDLE;
        m_axis_tvalid <= 1'b1;
        hit_out       <= hit;
        evict_out     <= !hit && !have_free;
        if (hit) begin
          hit_cnt <= hit_cnt + TW'(1);
        end else begin
          miss_cnt <= miss_cnt + TW'(1);
          if (have_free) begin
            valid[set_q][pos] <= 1'b1;
          end else begin
            evict_cnt <= evict_cnt + TW'(1);
          end
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {(sacl_pkg::OUT_DATA_W - sacl_pkg::RESULT_BITS)'(0),
                         evict_cnt, miss_cnt, hit_cnt, evict_out, hit_out};

`ifndef SYNTHESIS
  a_accept_to_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK))
    else $error("request not followed by its compare cycle");

  a_result_from_look: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == S_LOOK))
    else $error("result appeared without a compare cycle");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(hit_out && evict_out))
    else $error("hit and eviction flagged together");

  a_one_count_per_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> ((hit_cnt + miss_cnt) == ($past(hit_cnt) + $past(miss_cnt) + TW'(1))))
    else $error("totals did not advance by one access");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the set-associative cache lookup core with LRU replacement.
// It walks a directed table, then random address phases under several geometries and stall
// patterns; each result must match a pinned value or the cache model. Depends on sacl_pkg.
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_SETS = 1 << sacl_pkg::MAX_SET_BITS_DEF;
  localparam int NUM_LINES = NUM_SETS * sacl_pkg::WAYS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_SETTLE = 12;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int NUM_PHASES = 8;
  localparam logic [sacl_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [sacl_pkg::TOTAL_W-1:0] evict_total;
    logic [sacl_pkg::TOTAL_W-1:0] miss_total;
    logic [sacl_pkg::TOTAL_W-1:0] hit_total;
    logic                         evicted;
    logic                         hit;
  } lookup_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                         kind;
    logic [sacl_pkg::CFG_INDEX_W-1:0]  index;
    logic [sacl_pkg::CFG_DATA_W-1:0]   value;
    logic [sacl_pkg::ADDR_W-1:0]       addr;
    logic                              pinned;
    lookup_result_t                    res;
  } stim_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [sacl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [sacl_pkg::ADDR_W-1:0]      s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [sacl_pkg::OUT_DATA_W-1:0]  m_axis_tdata;

  set_assoc_cache_lru_lookup_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // Cache model state.
  logic [sacl_pkg::SET_BITS_W-1:0]   cfg_set_bits;
  logic [sacl_pkg::BLOCK_BITS_W-1:0] cfg_block_bits;
  logic [sacl_pkg::WAYS_USED_W-1:0]  cfg_ways_used;
  bit                                line_valid [NUM_LINES];
  logic [sacl_pkg::ADDR_W-1:0]       line_tag [NUM_LINES];
  logic [1:0]                        line_rank [NUM_LINES];
  logic [sacl_pkg::TOTAL_W-1:0]      hit_count;
  logic [sacl_pkg::TOTAL_W-1:0]      miss_count;
  logic [sacl_pkg::TOTAL_W-1:0]      evict_count;

  lookup_result_t expected_lookups [$];
  stim_row_t      stim_rows [$];
  logic [sacl_pkg::ADDR_W-1:0] tag_pool [6];

  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
    end
  endtask

  function automatic void geometry(output int sb, output int bb, output int ways);
    sb = (cfg_set_bits > sacl_pkg::MAX_SET_BITS_DEF) ? sacl_pkg::MAX_SET_BITS_DEF
                                                      : int'(cfg_set_bits);
    bb = int'(cfg_block_bits);
    ways = int'(cfg_ways_used);
    if (ways < 1) ways = 1;
    if (ways > sacl_pkg::WAYS_DEF) ways = sacl_pkg::WAYS_DEF;
  endfunction

  function automatic void promote_line(input int base, input int ways, input int pos,
                                       input int old_rank);
    int k;
    for (int w = 0; w < ways; w++) begin
      k = base + w;
      if (w != pos && line_valid[k] && line_rank[k] < old_rank) begin
        if (line_rank[k] < sacl_pkg::WAYS_DEF - 1) line_rank[k]++;
      end
    end
    line_rank[base + pos] = 2'd0;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr);
    int sb, bb, ways, base, hit_pos, free_pos, victim, best, k;
    logic [31:0] set_idx, tag;
    bit hit, have_free;
    lookup_result_t r;
    geometry(sb, bb, ways);
    hit = 1'b0;
    have_free = 1'b0;
    hit_pos = 0;
    free_pos = 0;
    set_idx = ((addr >> bb) & ((32'd1 << sb) - 32'd1)) & (NUM_SETS - 1);
    tag = (sb + bb >= 32) ? 32'd0 : (addr >> (sb + bb));
    base = int'(set_idx) * sacl_pkg::WAYS_DEF;
    for (int w = 0; w < ways; w++) begin
      k = base + w;
      if (line_valid[k]) begin
        if (!hit && line_tag[k] == tag) begin
          hit = 1'b1;
          hit_pos = w;
        end
      end else begin
        free_pos = w;
        have_free = 1'b1;
      end
    end
    r = '0;
    if (hit) begin
      hit_count++;
      promote_line(base, ways, hit_pos, line_rank[base + hit_pos]);
    end else if (have_free) begin
      miss_count++;
      line_valid[base + free_pos] = 1'b1;
      line_tag[base + free_pos] = tag;
      promote_line(base, ways, free_pos, 255);
    end else begin
      victim = 0;
      best = line_rank[base];
      for (int w = 1; w < ways; w++) begin
        if (line_rank[base + w] > best) begin
          best = line_rank[base + w];
          victim = w;
        end
      end
      miss_count++;
      evict_count++;
      r.evicted = 1'b1;
      line_tag[base + victim] = tag;
      promote_line(base, ways, victim, best);
    end
    r.hit = hit;
    r.hit_total = hit_count;
    r.miss_total = miss_count;
    r.evict_total = evict_count;
    return r;
  endfunction

  // Mostly a small pool of tags over a few sets, so that hits and evictions are common.
  function automatic logic [sacl_pkg::ADDR_W-1:0] make_addr();
    int sb, bb, ways;
    logic [31:0] tag, set_idx, offset;
    geometry(sb, bb, ways);
    if ($urandom_range(99) < 15) return $urandom();
    tag = tag_pool[$urandom_range(ways + 1)];
    set_idx = ($urandom_range(99) < 25) ? $urandom() : $urandom_range(3);
    set_idx = set_idx & ((32'd1 << sb) - 32'd1);
    offset = $urandom() & ((32'd1 << bb) - 32'd1);
    return (tag << (sb + bb)) | (set_idx << bb) | offset;
  endfunction

  function automatic stim_row_t row_access(input logic [sacl_pkg::ADDR_W-1:0] a);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ACCESS;
    r.addr = a;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input logic [sacl_pkg::CFG_INDEX_W-1:0] idx,
                                        input logic [sacl_pkg::CFG_DATA_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  function automatic stim_row_t row_pinned(input logic [sacl_pkg::ADDR_W-1:0] a,
                                           input logic h, input logic ev, input int ht,
                                           input int mt, input int et);
    stim_row_t r;
    r = row_access(a);
    r.pinned = 1'b1;
    r.res.hit = h;
    r.res.evicted = ev;
    r.res.hit_total = ht;
    r.res.miss_total = mt;
    r.res.evict_total = et;
    return r;
  endfunction

  task automatic send_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr, input logic pinned,
                             input lookup_result_t pinned_res);
    lookup_result_t predicted;
    predicted = predict_lookup(addr);
    expected_lookups.push_back(pinned ? pinned_res : predicted);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= addr;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (expected_lookups.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [sacl_pkg::CFG_INDEX_W-1:0] idx,
                         input logic [sacl_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      sacl_pkg::REG_SET_BITS: cfg_set_bits = val[sacl_pkg::SET_BITS_W-1:0];
      sacl_pkg::REG_BLOCK_BITS: cfg_block_bits = val[sacl_pkg::BLOCK_BITS_W-1:0];
      sacl_pkg::REG_WAYS_USED: cfg_ways_used = val[sacl_pkg::WAYS_USED_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    lookup_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = lookup_result_t'(m_axis_tdata[sacl_pkg::RESULT_BITS-1:0]);
      if (expected_lookups.size() == 0) begin
        report_mismatch("result arrived with no request pending");
      end else begin
        want = expected_lookups.pop_front();
        check_field("hit", 32'(got.hit), 32'(want.hit));
        check_field("evicted", 32'(got.evicted), 32'(want.evicted));
        check_field("hit_total", got.hit_total, want.hit_total);
        check_field("miss_total", got.miss_total, want.miss_total);
        check_field("evict_total", got.evict_total, want.evict_total);
      end
    end
  end

  int phase_sb [NUM_PHASES] = '{0, 6, 7, 3, 2, 2, 0, 0};
  int phase_bb [NUM_PHASES] = '{0, 26, 31, 4, 5, 5, 0, 0};
  int phase_ways [NUM_PHASES] = '{1, 4, 7, 0, 4, 2, 0, 0};
  int phase_tx [NUM_PHASES] = '{0, 51, 0, 26, 0, 51, 0, 26};
  int phase_rx [NUM_PHASES] = '{0, 0, 51, 26, 0, 0, 51, 26};

  initial begin
    stim_row_t row;
    cfg_set_bits = '0;
    cfg_block_bits = '0;
    cfg_ways_used = 3'd1;
    foreach (line_valid[i]) line_valid[i] = 1'b0;
    hit_count = '0;
    miss_count = '0;
    evict_count = '0;

    stim_rows = '{
      row_pinned(32'h0000_0000, 1'b0, 1'b0, 0, 1, 0),
      row_pinned(32'h0000_0000, 1'b1, 1'b0, 1, 1, 0),
      row_pinned(32'hFFFF_FFFF, 1'b0, 1'b1, 1, 2, 1),
      row_pinned(32'hFFFF_FFFF, 1'b1, 1'b0, 2, 2, 1),
      row_cfg(sacl_pkg::REG_WAYS_USED, 5'd4),
      row_access(32'h0000_0000), row_access(32'h0000_0001),
      row_access(32'h0000_0002), row_access(32'h0000_0003),
      row_access(32'h0000_0004), row_access(32'h0000_0000),
      row_cfg(sacl_pkg::REG_SET_BITS, 5'd6), row_cfg(sacl_pkg::REG_BLOCK_BITS, 5'd26),
      row_access(32'hFC00_0000), row_access(32'h03FF_FFFF), row_access(32'hFFFF_FFFF),
      row_cfg(sacl_pkg::REG_SET_BITS, 5'd7), row_cfg(sacl_pkg::REG_BLOCK_BITS, 5'd31),
      row_access(32'h8000_0000), row_access(32'h7FFF_FFFF), row_access(32'h8000_0000),
      row_cfg(REG_UNUSED, 5'd31),
      row_cfg(sacl_pkg::REG_SET_BITS, 5'd26), row_cfg(sacl_pkg::REG_BLOCK_BITS, 5'd0),
      row_cfg(sacl_pkg::REG_WAYS_USED, 5'd0),
      row_access(32'h0000_0000), row_access(32'h0000_0004), row_access(32'h0000_0000),
      row_cfg(sacl_pkg::REG_WAYS_USED, 5'd7),
      row_access(32'h0000_0008), row_access(32'h0000_000C), row_access(32'h0000_0008),
      row_cfg(sacl_pkg::REG_WAYS_USED, 5'd2),
      row_access(32'h0000_0000), row_access(32'h0000_0010)
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        cfg_put(row.index, row.value);
      end else begin
        send_lookup(row.addr, row.pinned, row.res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      tx_idle_pct = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      if (p >= 6) begin
        cfg_put(sacl_pkg::REG_SET_BITS, 5'($urandom_range(7)));
        cfg_put(sacl_pkg::REG_BLOCK_BITS, 5'($urandom_range(12)));
        cfg_put(sacl_pkg::REG_WAYS_USED, 5'($urandom_range(7)));
      end else begin
        cfg_put(sacl_pkg::REG_SET_BITS, 5'(phase_sb[p]));
        cfg_put(sacl_pkg::REG_BLOCK_BITS, 5'(phase_bb[p]));
        cfg_put(sacl_pkg::REG_WAYS_USED, 5'(phase_ways[p]));
      end
      foreach (tag_pool[i]) tag_pool[i] = $urandom();
      // In one phase the receiver holds off long enough for the core to back up.
      if (p == 4) hold_req = LONG_HOLD;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_lookup(make_addr(), 1'b0, '0);
      end
    end

    drain();
    repeat (END_SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
